// ===== sv/hmq_pkg.sv =====
// Shared types and constants for the binary min-heap priority queue.
// Depends on nothing; every other file refers to it by scoped names.
package hmq_pkg;

	localparam int CAPACITY = 1024;
	localparam int ADDR_W   = $clog2(CAPACITY);
	localparam int POS_W    = 11;
	localparam int KEY_W    = 32;

	localparam logic [1:0] OP_INSERT  = 2'd0;
	localparam logic [1:0] OP_EXTRACT = 2'd1;
	localparam logic [1:0] OP_ERASE   = 2'd2;

	localparam logic [1:0] ST_OK    = 2'd0;
	localparam logic [1:0] ST_EMPTY = 2'd1;
	localparam logic [1:0] ST_FULL  = 2'd2;
	localparam logic [1:0] ST_RANGE = 2'd3;

	typedef struct packed {
		logic [1:0]              opcode;
		logic signed [KEY_W-1:0] key_in;
		logic [POS_W-1:0]        position_in;
	} hmq_req_t;

	typedef struct packed {
		logic signed [KEY_W-1:0] removed_key;
		logic [POS_W-1:0]        final_position;
		logic [1:0]              status;
		logic [POS_W-1:0]        occupancy;
	} hmq_rsp_t;

	typedef struct packed {
		logic              we;
		logic [ADDR_W-1:0] waddr;
		logic [KEY_W-1:0]  wdata;
		logic [ADDR_W-1:0] raddr_a;
		logic [ADDR_W-1:0] raddr_b;
	} hmq_mem_req_t;

	typedef struct packed {
		logic [KEY_W-1:0] rdata_a;
		logic [KEY_W-1:0] rdata_b;
	} hmq_mem_rsp_t;

	typedef enum logic [2:0] {
		S_IDLE,
		S_LOAD,
		S_UP_RD,
		S_UP_CMP,
		S_DN_RD,
		S_DN_CMP,
		S_DONE
	} hmq_state_t;

endpackage

// ===== sv/hmq_ram.sv =====
// Key store: one write port, two registered read ports.
// Depends on hmq_pkg for widths and the port structs.
module hmq_ram (
	input  logic                  clk,
	input  hmq_pkg::hmq_mem_req_t req,
	output hmq_pkg::hmq_mem_rsp_t rsp
);

	logic [hmq_pkg::KEY_W-1:0] mem [hmq_pkg::CAPACITY];

	always_ff @(posedge clk) begin
		if (req.we) begin
			mem[req.waddr] <= req.wdata;
		end
		rsp.rdata_a <= mem[req.raddr_a];
		rsp.rdata_b <= mem[req.raddr_b];
	end

endmodule

// ===== sv/hmq_ctrl.sv =====
// Sequencer and datapath of the heap: bounds checks, sift up and sift down.
// Depends on hmq_pkg; drives the key store in hmq_ram.
module hmq_ctrl (
	input  logic                  clk,
	input  logic                  arst_n,
	input  logic                  start,
	input  hmq_pkg::hmq_req_t     req,
	output logic                  busy,
	output logic                  done,
	output hmq_pkg::hmq_rsp_t     rsp,
	output hmq_pkg::hmq_mem_req_t mem_req,
	input  hmq_pkg::hmq_mem_rsp_t mem_rsp
);

	localparam int POS_W  = hmq_pkg::POS_W;
	localparam int ADDR_W = hmq_pkg::ADDR_W;
	localparam int KEY_W  = hmq_pkg::KEY_W;

	hmq_pkg::hmq_state_t state_q, state_d;

	logic [POS_W-1:0]        count_q;
	logic [POS_W-1:0]        pos_q;
	logic signed [KEY_W-1:0] key_q;
	logic signed [KEY_W-1:0] removed_q;
	logic [POS_W-1:0]        final_q;
	logic [1:0]              status_q;
	logic [1:0]              op_q;
	logic                    erase_first_q;

	logic                    accept;
	logic                    full;
	logic                    pos_bad;
	logic [POS_W-1:0]        parent;
	logic [POS_W:0]          left;
	logic [POS_W:0]          right;
	logic                    left_ok;
	logic                    right_ok;
	logic signed [KEY_W-1:0] rd_a;
	logic signed [KEY_W-1:0] rd_b;
	logic                    up_less;
	logic                    up_turn;
	logic                    pick_l;
	logic                    pick_r;
	logic signed [KEY_W-1:0] cur_min;

	assign accept  = start && (state_q == hmq_pkg::S_IDLE);
	assign full    = count_q >= POS_W'(hmq_pkg::CAPACITY);
	assign pos_bad = (req.position_in == '0) || (req.position_in > count_q);

	assign parent   = pos_q >> 1;
	assign left     = {pos_q, 1'b0};
	assign right    = {pos_q, 1'b1};
	assign left_ok  = left <= {1'b0, count_q};
	assign right_ok = right <= {1'b0, count_q};

	assign rd_a = $signed(mem_rsp.rdata_a);
	assign rd_b = $signed(mem_rsp.rdata_b);

	// sift up: move above a strictly greater parent; an erase may turn downward
	assign up_less = (pos_q > POS_W'(1)) && (key_q < rd_a);
	assign up_turn = erase_first_q && (rd_a < key_q);

	// sift down: left child first, right child only if strictly smaller still
	assign pick_l  = left_ok && (rd_a < key_q);
	assign cur_min = pick_l ? rd_a : key_q;
	assign pick_r  = right_ok && (rd_b < cur_min);

	always_comb begin
		state_d = state_q;
		unique case (state_q)
			hmq_pkg::S_IDLE: begin
				if (start) begin
					priority case (req.opcode)
						hmq_pkg::OP_INSERT:  state_d = full ? hmq_pkg::S_DONE : hmq_pkg::S_UP_RD;
						hmq_pkg::OP_EXTRACT: state_d = (count_q == '0) ? hmq_pkg::S_DONE
						                                               : hmq_pkg::S_LOAD;
						hmq_pkg::OP_ERASE:   state_d = pos_bad ? hmq_pkg::S_DONE : hmq_pkg::S_LOAD;
						default:             state_d = hmq_pkg::S_DONE;
					endcase
				end
			end
			hmq_pkg::S_LOAD: begin
				if (op_q == hmq_pkg::OP_EXTRACT) begin
					state_d = (count_q == POS_W'(1)) ? hmq_pkg::S_DONE : hmq_pkg::S_DN_RD;
				end else if (pos_q == count_q) begin
					state_d = hmq_pkg::S_DONE;
				end else begin
					state_d = (pos_q == POS_W'(1)) ? hmq_pkg::S_DN_RD : hmq_pkg::S_UP_RD;
				end
			end
			hmq_pkg::S_UP_RD:  state_d = hmq_pkg::S_UP_CMP;
			hmq_pkg::S_UP_CMP: begin
				if (up_less) begin
					state_d = hmq_pkg::S_UP_RD;
				end else if (up_turn) begin
					state_d = hmq_pkg::S_DN_RD;
				end else begin
					state_d = hmq_pkg::S_DONE;
				end
			end
			hmq_pkg::S_DN_RD:  state_d = hmq_pkg::S_DN_CMP;
			hmq_pkg::S_DN_CMP: state_d = (pick_l || pick_r) ? hmq_pkg::S_DN_RD : hmq_pkg::S_DONE;
			hmq_pkg::S_DONE:   state_d = hmq_pkg::S_IDLE;
			default:           state_d = hmq_pkg::S_IDLE;
		endcase
	end

	always_comb begin
		mem_req = '0;
		unique case (state_q)
			hmq_pkg::S_IDLE: begin
				mem_req.raddr_a = (req.opcode == hmq_pkg::OP_EXTRACT) ? '0
				                                                      : ADDR_W'(req.position_in - 1'b1);
				mem_req.raddr_b = ADDR_W'(count_q - 1'b1);
			end
			hmq_pkg::S_UP_RD: begin
				mem_req.raddr_a = ADDR_W'(parent - 1'b1);
			end
			hmq_pkg::S_UP_CMP: begin
				mem_req.we    = 1'b1;
				mem_req.waddr = ADDR_W'(pos_q - 1'b1);
				mem_req.wdata = up_less ? rd_a : key_q;
				mem_req.we    = !up_turn || up_less;
			end
			hmq_pkg::S_DN_RD: begin
				mem_req.raddr_a = ADDR_W'(left - 1'b1);
				mem_req.raddr_b = ADDR_W'(left);
			end
			hmq_pkg::S_DN_CMP: begin
				mem_req.we    = 1'b1;
				mem_req.waddr = ADDR_W'(pos_q - 1'b1);
				mem_req.wdata = pick_r ? rd_b : (pick_l ? rd_a : key_q);
			end
			default: begin
				mem_req = '0;
			end
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= hmq_pkg::S_IDLE;
			count_q <= '0;
		end else begin
			state_q <= state_d;
			if (accept && req.opcode == hmq_pkg::OP_INSERT && !full) begin
				count_q <= count_q + 1'b1;
			end else if (state_q == hmq_pkg::S_LOAD) begin
				count_q <= count_q - 1'b1;
			end
		end
	end

	always_ff @(posedge clk) begin
		unique case (state_q)
			hmq_pkg::S_IDLE: begin
				if (start) begin
					op_q          <= req.opcode;
					removed_q     <= '0;
					final_q       <= '0;
					erase_first_q <= 1'b0;
					key_q         <= req.key_in;
					pos_q         <= (req.opcode == hmq_pkg::OP_INSERT) ? count_q + 1'b1
					               : (req.opcode == hmq_pkg::OP_EXTRACT) ? POS_W'(1)
					               : req.position_in;
					priority case (req.opcode)
						hmq_pkg::OP_INSERT:  status_q <= full ? hmq_pkg::ST_FULL : hmq_pkg::ST_OK;
						hmq_pkg::OP_EXTRACT: status_q <= (count_q == '0) ? hmq_pkg::ST_EMPTY
						                                                 : hmq_pkg::ST_OK;
						hmq_pkg::OP_ERASE:   status_q <= pos_bad ? hmq_pkg::ST_RANGE : hmq_pkg::ST_OK;
						default:             status_q <= hmq_pkg::ST_OK;
					endcase
				end
			end
			hmq_pkg::S_LOAD: begin
				removed_q     <= rd_a;
				key_q         <= rd_b;
				erase_first_q <= (op_q == hmq_pkg::OP_ERASE);
			end
			hmq_pkg::S_UP_CMP: begin
				erase_first_q <= 1'b0;
				if (up_less) begin
					pos_q <= parent;
				end else if (!up_turn) begin
					final_q <= pos_q;
				end
			end
			hmq_pkg::S_DN_CMP: begin
				erase_first_q <= 1'b0;
				if (pick_r) begin
					pos_q <= right[POS_W-1:0];
				end else if (pick_l) begin
					pos_q <= left[POS_W-1:0];
				end else begin
					final_q <= pos_q;
				end
			end
			default: begin
			end
		endcase
	end

	assign busy               = state_q != hmq_pkg::S_IDLE;
	assign done               = state_q == hmq_pkg::S_DONE;
	assign rsp.removed_key    = removed_q;
	assign rsp.final_position = final_q;
	assign rsp.status         = status_q;
	assign rsp.occupancy      = count_q;

endmodule

// ===== sv/binary_min_heap_queue_top.sv =====
// Top level of the binary min-heap priority queue.
// Depends on hmq_pkg, hmq_ram and hmq_ctrl.

// A request transfers at a rising edge with start high and busy low; its one
// result appears on rsp for exactly one cycle with done high, and busy stays
// high until that cycle is over, so a new request can be issued the cycle
// after done. The receiver cannot stall, so capture rsp whenever done is seen.
// A flagged request (full, empty, bad position, unused opcode) goes from idle
// straight to the result state; an extract of the only key or an erase of the
// last slot passes through the load state first. An insert climbs at most 10
// heap levels and a removal moves a key at most 9 at 1024 entries. An erase
// whose moved key sinks from a slot below the root makes the parent compare
// first. The worst case is an insert that climbs from slot 1024 to the root.
// Each sift level is a read state and a compare-and-write state on the
// synchronous RAM. The store needs no clearing after reset; only slots
// 1..occupancy are ever used.
module binary_min_heap_queue_top (
	input  logic              clk,
	input  logic              arst_n,
	input  logic              start,
	input  hmq_pkg::hmq_req_t req,
	output logic              busy,
	output logic              done,
	output hmq_pkg::hmq_rsp_t rsp
);

	hmq_pkg::hmq_mem_req_t mem_req;
	hmq_pkg::hmq_mem_rsp_t mem_rsp;

	// The sifting key is held in a register and written only once it settles;
	// each level writes one slot and the next level reads other slots, so a
	// read never meets a pending write to the same entry.
	hmq_ctrl u_ctrl (
		.clk     (clk),
		.arst_n  (arst_n),
		.start   (start),
		.req     (req),
		.busy    (busy),
		.done    (done),
		.rsp     (rsp),
		.mem_req (mem_req),
		.mem_rsp (mem_rsp)
	);

	hmq_ram u_ram (
		.clk (clk),
		.req (mem_req),
		.rsp (mem_rsp)
	);

	// a transfer always makes the block busy in the next cycle
	assert property (@(posedge clk) disable iff (!arst_n)
		start && !busy |=> busy)
		else $error("request transfer did not start work");

	// the result cycle hands back to idle
	assert property (@(posedge clk) disable iff (!arst_n)
		done |=> !busy)
		else $error("block still busy after result");

	// no back-to-back writes: every write follows a read cycle
	assert property (@(posedge clk) disable iff (!arst_n)
		mem_req.we |=> !mem_req.we)
		else $error("back-to-back key store writes");

	// a flagged request reports no key and no move
	assert property (@(posedge clk) disable iff (!arst_n)
		done && (rsp.status == hmq_pkg::ST_FULL || rsp.status == hmq_pkg::ST_EMPTY
		|| rsp.status == hmq_pkg::ST_RANGE)
		|-> rsp.removed_key == '0 && rsp.final_position == '0)
		else $error("flagged request returned data");

endmodule

// ===== tb/tb_top.sv =====
// Self-checking testbench for binary_min_heap_queue_top (min-heap priority queue).
// Depends on hmq_pkg for the request/response structs and codes; predicts every
// response with a behavioral heap and compares it field by field.
module tb_top;
	timeunit 1ns;
	timeprecision 1ps;

	localparam int POS_W    = hmq_pkg::POS_W;
	localparam int KEY_W    = hmq_pkg::KEY_W;
	localparam int CAPACITY = hmq_pkg::CAPACITY;

	// The package names three operations; the fourth encoding is a no-op request.
	localparam logic [1:0] OP_UNUSED = 2'd3;
	localparam int         POS_MAX   = (1 << POS_W) - 1;

	logic              clk    = 1'b0;
	logic              arst_n = 1'b0;
	logic              start  = 1'b0;
	hmq_pkg::hmq_req_t req    = '0;
	logic              busy;
	logic              done;
	hmq_pkg::hmq_rsp_t rsp;

	binary_min_heap_queue_top DUT (
		.clk    (clk),
		.arst_n (arst_n),
		.start  (start),
		.req    (req),
		.busy   (busy),
		.done   (done),
		.rsp    (rsp)
	);

	initial begin
		forever #5 clk = ~clk;
	end

	// Stimulus waiting to be sent, and responses predicted for transferred requests.
	hmq_pkg::hmq_req_t req_q[$];
	hmq_pkg::hmq_rsp_t expected_rsp_q[$];
	hmq_pkg::hmq_rsp_t oldest_rsp;

	int unsigned gen_count;      // occupancy as the generator expects it
	int unsigned sent_items;
	int unsigned accepted_items;
	int unsigned mismatch_count;

	// Shadow heap, one-based like the hardware store.
	logic signed [KEY_W-1:0] heap_keys [1:CAPACITY];
	int unsigned             heap_size;

	// Coverage tallies for the closing summary.
	int unsigned n_insert, n_extract, n_erase, n_unused;
	int unsigned n_empty, n_full, n_range, n_moved, peak_size;

	// ------------------------------------------------------------------
	// Heap predictor
	// ------------------------------------------------------------------
	function automatic void swap_keys(int unsigned a, int unsigned b);
		logic signed [KEY_W-1:0] t;
		t            = heap_keys[a];
		heap_keys[a] = heap_keys[b];
		heap_keys[b] = t;
	endfunction

	// Climb while strictly smaller than the parent; an equal parent stops the climb.
	function automatic int unsigned sift_key_up(int unsigned p);
		while (p > 1 && heap_keys[p] < heap_keys[p / 2]) begin
			swap_keys(p, p / 2);
			p = p / 2;
		end
		return p;
	endfunction

	// Descend toward the strictly smaller child; left wins ties against right.
	function automatic int unsigned sift_key_down(int unsigned p);
		int unsigned l;
		int unsigned r;
		int unsigned pick;
		bit          settled;
		settled = 1'b0;
		while (!settled) begin
			l    = 2 * p;
			r    = l + 1;
			pick = p;
			if (l <= heap_size && heap_keys[l] < heap_keys[pick])
				pick = l;
			if (r <= heap_size && heap_keys[r] < heap_keys[pick])
				pick = r;
			if (pick == p) begin
				settled = 1'b1;
			end else begin
				swap_keys(p, pick);
				p = pick;
			end
		end
		return p;
	endfunction

	function automatic hmq_pkg::hmq_rsp_t predict_heap_response(hmq_pkg::hmq_req_t rq);
		hmq_pkg::hmq_rsp_t rs;
		int unsigned       p;
		rs = '0;
		p  = rq.position_in;
		case (rq.opcode)
			hmq_pkg::OP_INSERT: begin
				n_insert++;
				if (heap_size >= CAPACITY) begin
					rs.status = hmq_pkg::ST_FULL;
				end else begin
					heap_size++;
					heap_keys[heap_size] = rq.key_in;
					rs.final_position    = POS_W'(sift_key_up(heap_size));
				end
			end
			hmq_pkg::OP_EXTRACT: begin
				n_extract++;
				if (heap_size == 0) begin
					rs.status = hmq_pkg::ST_EMPTY;
				end else begin
					rs.removed_key = heap_keys[1];
					if (heap_size >= 2) begin
						heap_keys[1] = heap_keys[heap_size];
						heap_size--;
						rs.final_position = POS_W'(sift_key_down(1));
					end else begin
						heap_size = 0;
					end
				end
			end
			hmq_pkg::OP_ERASE: begin
				n_erase++;
				if (p < 1 || p > heap_size) begin
					rs.status = hmq_pkg::ST_RANGE;
				end else begin
					rs.removed_key = heap_keys[p];
					if (p == heap_size) begin
						heap_size--;
					end else begin
						heap_keys[p] = heap_keys[heap_size];
						heap_size--;
						// Root always goes down; elsewhere go up unless above the parent.
						if (p > 1 && !(heap_keys[p / 2] < heap_keys[p]))
							rs.final_position = POS_W'(sift_key_up(p));
						else
							rs.final_position = POS_W'(sift_key_down(p));
					end
				end
			end
			default: begin
				n_unused++;
			end
		endcase
		rs.occupancy = POS_W'(heap_size);
		case (rs.status)
			hmq_pkg::ST_EMPTY: n_empty++;
			hmq_pkg::ST_FULL:  n_full++;
			hmq_pkg::ST_RANGE: n_range++;
			default:  ;
		endcase
		if (rs.final_position != 0)
			n_moved++;
		if (heap_size > peak_size)
			peak_size = heap_size;
		return rs;
	endfunction

	// ------------------------------------------------------------------
	// Stimulus helpers
	// ------------------------------------------------------------------
	// Append a request and track the occupancy it leaves behind, so later
	// erase positions can be aimed at live slots.
	task automatic queue_request(input logic [1:0] op, input logic signed [KEY_W-1:0] key,
		input logic [POS_W-1:0] pos);
		hmq_pkg::hmq_req_t rq;
		rq.opcode      = op;
		rq.key_in      = key;
		rq.position_in = pos;
		req_q.push_back(rq);
		case (op)
			hmq_pkg::OP_INSERT:  if (gen_count < CAPACITY) gen_count++;
			hmq_pkg::OP_EXTRACT: if (gen_count > 0) gen_count--;
			hmq_pkg::OP_ERASE:   if (pos >= 1 && pos <= gen_count) gen_count--;
			default:    ;
		endcase
	endtask

	// Mix dense keys (to force ties), the extremes and full-range values.
	function automatic logic signed [KEY_W-1:0] pick_key();
		case ($urandom_range(9))
			0, 1, 2: return KEY_W'($urandom_range(16) - 8);
			3: begin
				case ($urandom_range(3))
					0:       return 32'sh8000_0000;
					1:       return 32'sh7fff_ffff;
					2:       return 32'sh0000_0000;
					default: return -32'sd1;
				endcase
			end
			default: return $urandom;
		endcase
	endfunction

	// Favor live slots, with extra weight on the root and the last slot;
	// now and then aim past the end or at slot zero.
	function automatic logic [POS_W-1:0] pick_erase_pos();
		if (gen_count == 0 || $urandom_range(9) == 0) begin
			case ($urandom_range(2))
				0:       return '0;
				1:       return POS_W'(gen_count + 1);
				default: return POS_W'($urandom_range(POS_MAX, gen_count + 1));
			endcase
		end
		case ($urandom_range(5))
			0:       return POS_W'(1);
			1:       return POS_W'(gen_count);
			default: return POS_W'($urandom_range(gen_count, 1));
		endcase
	endfunction

	// One random request from the given weights (percent); the remainder
	// goes to the unused opcode, which does not count as real work.
	task automatic add_random_request(input int ins_pct, input int ext_pct, input int ers_pct,
		output bit counted);
		int r;
		r       = $urandom_range(99);
		counted = 1'b1;
		if (r < ins_pct)
			queue_request(hmq_pkg::OP_INSERT, pick_key(), POS_W'($urandom_range(POS_MAX)));
		else if (r < ins_pct + ext_pct)
			queue_request(hmq_pkg::OP_EXTRACT, $urandom, POS_W'($urandom_range(POS_MAX)));
		else if (r < ins_pct + ext_pct + ers_pct)
			queue_request(hmq_pkg::OP_ERASE, $urandom, pick_erase_pos());
		else begin
			queue_request(OP_UNUSED, $urandom, POS_W'($urandom_range(POS_MAX)));
			counted = 1'b0;
		end
	endtask

	task automatic check_field(input string name, input logic signed [63:0] want,
		input logic signed [63:0] got);
		if (want !== got) begin
			$error("%s: expected %0d, got %0d", name, want, got);
			mismatch_count++;
		end
	endtask

	// ------------------------------------------------------------------
	// Driver: present requests from req_q, predict each on transfer.
	// ------------------------------------------------------------------
	always @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			start <= 1'b0;
			req   <= '0;
		end else begin
			// A transfer happened at this edge: predict its response now.
			if (start && !busy) begin
				expected_rsp_q.push_back(predict_heap_response(req));
				accepted_items++;
			end
			// Hold a pending request until it transfers; otherwise decide
			// this cycle whether to offer the next one or idle.
			if (!start || !busy) begin
				if (req_q.size() != 0 &&
					$urandom_range(99) >= ((sent_items >= 500 && sent_items < 800) ? 0 : 12)) begin
					req   <= req_q.pop_front();
					start <= 1'b1;
					sent_items++;
				end else begin
					start <= 1'b0;
				end
			end
		end
	end

	// ------------------------------------------------------------------
	// Monitor: results cannot be stalled, so take every done pulse.
	// ------------------------------------------------------------------
	always @(posedge clk) begin
		if (arst_n && done) begin
			if (expected_rsp_q.size() == 0) begin
				$error("result with no request outstanding: removed_key %0d occupancy %0d",
					rsp.removed_key, rsp.occupancy);
				mismatch_count++;
			end else begin
				oldest_rsp = expected_rsp_q.pop_front();
				check_field("removed_key", $signed(oldest_rsp.removed_key),
					$signed(rsp.removed_key));
				check_field("final_position", oldest_rsp.final_position, rsp.final_position);
				check_field("status", oldest_rsp.status, rsp.status);
				check_field("occupancy", oldest_rsp.occupancy, rsp.occupancy);
			end
		end
	end

	// ------------------------------------------------------------------
	// Stimulus plan, reset and end of run
	// ------------------------------------------------------------------
	initial begin
		int unsigned total_items;
		int unsigned n;
		bit          counted;

		// Directed: empty-heap flags, the unused opcode, a single key in and
		// out, the key extremes, equal-parent ties, then erase of the last
		// slot, of the root and of two middle slots, and erase past the end.
		queue_request(hmq_pkg::OP_EXTRACT, $urandom, POS_W'(POS_MAX));
		queue_request(hmq_pkg::OP_ERASE, $urandom, '0);
		queue_request(hmq_pkg::OP_ERASE, $urandom, POS_W'(1));
		queue_request(OP_UNUSED, $urandom, POS_W'($urandom_range(POS_MAX)));
		queue_request(hmq_pkg::OP_INSERT, 32'sh7fff_ffff, '0);
		queue_request(hmq_pkg::OP_EXTRACT, '0, '0);
		queue_request(hmq_pkg::OP_INSERT, 32'sd5, POS_W'(POS_MAX));
		queue_request(hmq_pkg::OP_INSERT, 32'sd5, '0);
		queue_request(hmq_pkg::OP_INSERT, 32'sh8000_0000, '0);
		queue_request(hmq_pkg::OP_INSERT, -32'sd1, '0);
		queue_request(hmq_pkg::OP_INSERT, 32'sd0, '0);
		queue_request(hmq_pkg::OP_INSERT, 32'sd3, '0);
		queue_request(hmq_pkg::OP_INSERT, 32'sd5, '0);
		queue_request(hmq_pkg::OP_INSERT, 32'sh7fff_ffff, '0);
		queue_request(hmq_pkg::OP_INSERT, -32'sd1, '0);
		queue_request(hmq_pkg::OP_ERASE, -32'sd1, POS_W'(gen_count));
		queue_request(hmq_pkg::OP_ERASE, '0, POS_W'(1));
		queue_request(hmq_pkg::OP_ERASE, '0, POS_W'(3));
		queue_request(hmq_pkg::OP_ERASE, '0, POS_W'(2));
		queue_request(hmq_pkg::OP_ERASE, '0, POS_W'(gen_count + 1));
		queue_request(hmq_pkg::OP_ERASE, '0, POS_W'(POS_MAX));
		queue_request(hmq_pkg::OP_EXTRACT, 32'sh8000_0000, '0);
		queue_request(hmq_pkg::OP_EXTRACT, 32'sh7fff_ffff, POS_W'(POS_MAX));

		// Churn on a small heap: it drains often, so the flags keep firing.
		n = 0;
		while (n < 250) begin
			add_random_request(52, 22, 22, counted);
			if (counted)
				n++;
		end

		// Fill to capacity with a few removals mixed in, then push on the
		// full heap, erase the top slot and probe positions past the end.
		while (gen_count < CAPACITY) begin
			if ($urandom_range(19) == 0)
				add_random_request(0, 50, 50, counted);
			else
				queue_request(hmq_pkg::OP_INSERT, pick_key(), POS_W'($urandom_range(POS_MAX)));
		end
		repeat (3)
			queue_request(hmq_pkg::OP_INSERT, pick_key(), POS_W'($urandom_range(POS_MAX)));
		queue_request(hmq_pkg::OP_ERASE, $urandom, POS_W'(CAPACITY));
		queue_request(hmq_pkg::OP_INSERT, pick_key(), '0);
		queue_request(hmq_pkg::OP_ERASE, $urandom, POS_W'(CAPACITY + 1));
		queue_request(hmq_pkg::OP_ERASE, $urandom, POS_W'(POS_MAX));
		queue_request(hmq_pkg::OP_INSERT, pick_key(), POS_W'(POS_MAX));
		queue_request(hmq_pkg::OP_EXTRACT, $urandom, '0);

		// Drain with removals dominating, so the heap shrinks back from full.
		n = 0;
		while (n < 300) begin
			add_random_request(15, 40, 40, counted);
			if (counted)
				n++;
		end
		total_items = req_q.size();

		// Hold reset, then release it once.
		repeat (12) @(posedge clk);
		arst_n <= 1'b1;

		// Wait for every request to transfer and every result to return,
		// then allow for a stray late result.
		while (accepted_items < total_items || expected_rsp_q.size() != 0)
			@(posedge clk);
		repeat (40) @(posedge clk);

		$display("Ran %0d requests: %0d insert, %0d extract-min, %0d erase, %0d unused opcode.",
			accepted_items, n_insert, n_extract, n_erase, n_unused);
		$display("Flagged %0d empty, %0d full, %0d bad position; %0d keys moved; peak size %0d.",
			n_empty, n_full, n_range, n_moved, peak_size);
		if (mismatch_count == 0)
			$display("No mismatches found");
		else
			$display("Mismatches found");
		$finish;
	end

	// Watchdog: a hung handshake ends the run as a failure.
	initial begin
		#5_000_000;
		$display("Mismatches found");
		$finish;
	end

endmodule
